### rtl/page_frame_pool_replacer_defines.svh
// assertion macros for the page frame pool replacer
`ifndef PAGE_FRAME_POOL_REPLACER_DEFINES_SVH
`define PAGE_FRAME_POOL_REPLACER_DEFINES_SVH
`ifndef SYNTHESIS
`define PFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define PFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define PFP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PFP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/pfp_pkg.sv
// shared types and constants for the page frame pool replacer
`default_nettype none
package pfp_pkg;
	localparam int NumFrames = 16;
	localparam int FrameIdxW = 4;
	localparam int FrameCntW = 5;
	localparam logic [31:0] EmptyMark = 32'hFFFF_FFFF;
	localparam logic [15:0] PinMax = 16'hFFFF;

	localparam logic [2:0] OP_PIN   = 3'd0;
	localparam logic [2:0] OP_UNPIN = 3'd1;
	localparam logic [2:0] OP_DIRTY = 3'd2;
	localparam logic [2:0] OP_FORCE = 3'd3;
	localparam logic [2:0] OP_FLUSH = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_NOEVICT = 2'd2;

	localparam logic [0:0] REG_STRATEGY = 1'd0;
	localparam logic [0:0] REG_FRAMES   = 1'd1;

	// one frame entry as seen by the scan unit
	typedef struct packed {
		logic [31:0] page;
		logic        dirty;
		logic [15:0] pins;
		logic [31:0] last_use;
		logic [31:0] loaded_at;
	} frame_t;

	// scan results handed back to the sequencer
	typedef struct packed {
		logic                 match_found;
		logic [FrameIdxW-1:0] match_idx;
		logic                 empty_found;
		logic [FrameIdxW-1:0] empty_idx;
		logic                 victim_found;
		logic [FrameIdxW-1:0] victim_idx;
	} scan_res_t;
endpackage
`default_nettype wire

### rtl/pfp_scan.sv
// shared scan unit: one frame per cycle, match, first empty and oldest stamp
`default_nettype none
module pfp_scan import pfp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 step,
	input  wire logic [FrameIdxW-1:0] idx,
	input  wire frame_t               entry,
	input  wire logic [30:0]          page_number,
	input  wire logic [1:0]           strategy,
	output scan_res_t                 res
);
	logic [31:0] best_q;
	logic [31:0] stamp;
	logic        better;

	// stamp compare for the selected strategy
	always_comb begin
		stamp  = (strategy == 2'd0) ? entry.loaded_at : entry.last_use;
		better = (strategy[1] == 1'b0) && (entry.pins == 16'd0) &&
			(!res.victim_found || stamp < best_q);
	end

	// accumulate results over the frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res    <= '0;
			best_q <= '0;
		end else if (start) begin
			res    <= '0;
			best_q <= '0;
		end else if (step) begin
			if (!res.match_found && entry.page == {1'b0, page_number}) begin
				res.match_found <= 1'b1;
				res.match_idx   <= idx;
			end
			if (!res.empty_found && entry.page == EmptyMark) begin
				res.empty_found <= 1'b1;
				res.empty_idx   <= idx;
			end
			if (better) begin
				res.victim_found <= 1'b1;
				res.victim_idx   <= idx;
				best_q           <= stamp;
			end
		end
	end
endmodule
`default_nettype wire

### rtl/page_frame_pool_replacer.sv
// an accepted word walks the n used frames in the scan state, then the exec state
// applies the op and the output state offers its result word
// flush walks the frames again and goes to the output state for each word it gives
// one item at a time: a new input word is taken only once the last result word is taken
// reset: all frames empty, clean, unpinned, stamps, clocks and counters zero,
// strategy fifo and sixteen frames in use
`default_nettype none
`include "page_frame_pool_replacer_defines.svh"
module page_frame_pool_replacer import pfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [30:0] page_number,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [3:0]       frame_index,
	output logic             hit,
	output logic             read_request,
	output logic             writeback,
	output logic [30:0]      writeback_page,
	output logic [3:0]       writeback_frame,
	output logic [15:0]      pin_count_now,
	output logic [31:0]      read_io_count,
	output logic [31:0]      write_io_count,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data
);
	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_EXEC, S_FLUSH, S_OUT} state_t;
	state_t state_q;

	frame_t frames_q [NumFrames];
	logic [1:0]           strategy_q;
	logic [FrameCntW-1:0] nframes_q;
	logic [2:0]           op_q;
	logic [30:0]          pn_q;
	logic [FrameIdxW:0]   cnt_q;
	logic [31:0]          use_clk_q, load_clk_q;
	logic                 flush_any_q;
	logic                 out_flush_q;
	scan_res_t            res;
	logic [FrameCntW-1:0] n_used;
	logic                 scan_start, scan_step;
	frame_t               cur;
	logic [FrameIdxW-1:0] cidx;

	assign cidx = cnt_q[FrameIdxW-1:0];
	assign cur  = frames_q[cidx];
	assign n_used = (nframes_q > FrameCntW'(NumFrames)) ? FrameCntW'(NumFrames) : nframes_q;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign scan_start = in_valid && in_ready;
	assign scan_step  = (state_q == S_SCAN) && (cnt_q < n_used);

	pfp_scan u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .step(scan_step),
		.idx(cidx), .entry(cur), .page_number(pn_q), .strategy(strategy_q), .res(res)
	);

	// sequencer, frame table and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < NumFrames; i++) begin
				frames_q[i] <= '{page: EmptyMark, dirty: 1'b0, pins: 16'd0,
					last_use: 32'd0, loaded_at: 32'd0};
			end
			strategy_q <= 2'd0; nframes_q <= 5'd16;
			use_clk_q <= '0; load_clk_q <= '0;
			read_io_count <= '0; write_io_count <= '0;
			out_valid <= 1'b0; cnt_q <= '0; flush_any_q <= 1'b0;
			out_flush_q <= 1'b0; op_q <= '0; pn_q <= '0;
			status <= '0; frame_index <= '0; hit <= 1'b0; read_request <= 1'b0;
			writeback <= 1'b0; writeback_page <= '0; writeback_frame <= '0;
			pin_count_now <= '0; last <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == REG_STRATEGY) strategy_q <= cfg_data[1:0];
						else nframes_q <= cfg_data;
					end
					if (in_valid) begin
						op_q <= opcode; pn_q <= page_number;
						cnt_q <= '0; state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q < n_used) cnt_q <= cnt_q + 1'b1;
					else state_q <= S_EXEC;
				end
				S_EXEC: begin
					status <= ST_OK; frame_index <= '0; hit <= 1'b0;
					read_request <= 1'b0; writeback <= 1'b0; writeback_page <= '0;
					writeback_frame <= '0; pin_count_now <= '0; last <= 1'b1;
					out_flush_q <= 1'b0;
					state_q <= S_OUT;
					case (op_q)
						OP_PIN: begin
							use_clk_q <= use_clk_q + 1'b1;
							if (res.match_found) begin
								if (frames_q[res.match_idx].pins != PinMax) begin
									frames_q[res.match_idx].pins <= frames_q[res.match_idx].pins + 1'b1;
									pin_count_now <= frames_q[res.match_idx].pins + 1'b1;
								end else pin_count_now <= PinMax;
								frames_q[res.match_idx].last_use <= use_clk_q + 1'b1;
								frame_index <= res.match_idx; hit <= 1'b1;
							end else if (res.empty_found || res.victim_found) begin
								logic [FrameIdxW-1:0] v;
								v = res.empty_found ? res.empty_idx : res.victim_idx;
								if (!res.empty_found && frames_q[v].dirty) begin
									writeback <= 1'b1;
									writeback_page <= frames_q[v].page[30:0];
									writeback_frame <= v;
									write_io_count <= write_io_count + 1'b1;
								end
								read_io_count <= read_io_count + 1'b1;
								load_clk_q <= load_clk_q + 1'b1;
								frames_q[v] <= '{page: {1'b0, pn_q}, dirty: 1'b0, pins: 16'd1,
									last_use: use_clk_q + 1'b1, loaded_at: load_clk_q + 1'b1};
								frame_index <= v; read_request <= 1'b1; pin_count_now <= 16'd1;
							end else status <= ST_NOEVICT;
						end
						OP_UNPIN, OP_DIRTY, OP_FORCE: begin
							if (!res.match_found) status <= ST_ABSENT;
							else begin
								frame_index <= res.match_idx;
								pin_count_now <= frames_q[res.match_idx].pins;
								if (op_q == OP_UNPIN) begin
									if (frames_q[res.match_idx].pins == 16'd0) begin
										status <= ST_ABSENT; pin_count_now <= '0;
									end else begin
										frames_q[res.match_idx].pins <= frames_q[res.match_idx].pins - 1'b1;
										pin_count_now <= frames_q[res.match_idx].pins - 1'b1;
									end
								end else if (op_q == OP_DIRTY) begin
									frames_q[res.match_idx].dirty <= 1'b1;
								end else if (!frames_q[res.match_idx].dirty) status <= ST_ABSENT;
								else begin
									frames_q[res.match_idx].dirty <= 1'b0;
									write_io_count <= write_io_count + 1'b1;
									writeback <= 1'b1;
									writeback_page <= frames_q[res.match_idx].page[30:0];
									writeback_frame <= res.match_idx;
								end
							end
						end
						OP_FLUSH: begin
							cnt_q <= '0; flush_any_q <= 1'b0; state_q <= S_FLUSH;
						end
						default: status <= ST_ABSENT;
					endcase
				end
				S_FLUSH: begin
					if (cnt_q >= n_used) begin
						if (!flush_any_q) begin
							status <= ST_OK; frame_index <= '0; writeback <= 1'b0;
							writeback_page <= '0; writeback_frame <= '0; last <= 1'b1;
							out_flush_q <= 1'b0; state_q <= S_OUT;
						end else state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (cur.dirty && cur.pins == 16'd0) begin
							frames_q[cidx].dirty <= 1'b0;
							write_io_count <= write_io_count + 1'b1;
							flush_any_q <= 1'b1;
							status <= ST_OK; frame_index <= cidx; hit <= 1'b0;
							read_request <= 1'b0; writeback <= 1'b1;
							writeback_page <= cur.page[30:0]; writeback_frame <= cidx;
							pin_count_now <= '0;
							last <= 1'b1;
							for (int j = 0; j < NumFrames; j++) begin
								if (j > int'(cidx) && j < int'(n_used) &&
									frames_q[j].dirty && frames_q[j].pins == 16'd0)
									last <= 1'b0;
							end
							out_flush_q <= 1'b1; state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						state_q <= (out_flush_q && !last) ? S_FLUSH : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a word is offered only from the output state
	`PFP_ASSERT_IMP(a_out_state, clk, arst_n, out_valid, state_q == S_OUT)
	// no input is taken while a word waits
	`PFP_ASSERT_IMP(a_busy, clk, arst_n, out_valid, !in_ready)
	// a delivered non-final word leads back to the flush walk
	`PFP_ASSERT_NXT(a_flush_cont, clk, arst_n, out_valid && out_ready && !last, state_q == S_FLUSH)
endmodule
`default_nettype wire

### sim/testbench.sv
// self-checking testbench for the page frame pool replacer
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import pfp_pkg::*;

	// one result word of the block
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  frame_index;
		logic        hit;
		logic        read_request;
		logic        writeback;
		logic [30:0] writeback_page;
		logic [3:0]  writeback_frame;
		logic [15:0] pin_count_now;
		logic [31:0] read_io_count;
		logic [31:0] write_io_count;
		logic        last;
	} result_word_t;

	// pool predictor plus queue of expected result words
	class pool_scoreboard;
		logic [31:0] page_of[NumFrames];
		logic        dirty_of[NumFrames];
		logic [15:0] pins_of[NumFrames];
		logic [31:0] used_at[NumFrames];
		logic [31:0] loaded_at[NumFrames];
		logic [31:0] use_clk, load_clk, reads, writes;
		logic [1:0]  strategy;
		logic [4:0]  frame_cnt;
		result_word_t pending[$];
		int errors, words_checked, hits, evictions, wb_seen;

		function new();
			for (int i = 0; i < NumFrames; i++) begin
				page_of[i] = EmptyMark;
				dirty_of[i] = 0;
				pins_of[i] = 0;
				used_at[i] = 0;
				loaded_at[i] = 0;
			end
			use_clk = 0; load_clk = 0; reads = 0; writes = 0;
			strategy = 0; frame_cnt = 16;
			errors = 0; words_checked = 0; hits = 0; evictions = 0; wb_seen = 0;
		endfunction

		function void write_reg(logic idx, logic [4:0] data);
			if (idx == REG_STRATEGY) strategy = data[1:0];
			else frame_cnt = data;
		endfunction

		function void push(logic [1:0] st, int fr, logic h, logic rd, logic wb,
			logic [31:0] wpg, int wfr, logic [15:0] pins, logic lst);
			result_word_t w;
			w.status = st;
			w.frame_index = fr[3:0];
			w.hit = h;
			w.read_request = rd;
			w.writeback = wb;
			w.writeback_page = wb ? wpg[30:0] : '0;
			w.writeback_frame = wb ? wfr[3:0] : '0;
			w.pin_count_now = pins;
			w.read_io_count = reads;
			w.write_io_count = writes;
			w.last = lst;
			pending.push_back(w);
		endfunction

		// predict the result words of one accepted input word
		function void note_input(logic [2:0] op, logic [30:0] pn);
			int n, f, v, cnt;
			logic [31:0] pg, best, s;
			logic wb;
			n = (frame_cnt > NumFrames) ? NumFrames : frame_cnt;
			pg = {1'b0, pn};
			f = -1;
			for (int i = 0; i < n; i++)
				if (f < 0 && page_of[i] == pg) f = i;
			if (op == OP_PIN) begin
				use_clk++;
				if (f >= 0) begin
					if (pins_of[f] != PinMax) pins_of[f]++;
					used_at[f] = use_clk;
					hits++;
					push(ST_OK, f, 1, 0, 0, 0, 0, pins_of[f], 1);
					return;
				end
				v = -1;
				for (int i = 0; i < n; i++)
					if (v < 0 && page_of[i] == EmptyMark) v = i;
				wb = 0;
				if (v < 0) begin
					if (strategy < 2) begin
						for (int i = 0; i < n; i++) begin
							if (pins_of[i] != 0) continue;
							s = (strategy == 0) ? loaded_at[i] : used_at[i];
							if (v < 0 || s < best) begin
								v = i;
								best = s;
							end
						end
					end
					if (v < 0) begin
						push(ST_NOEVICT, 0, 0, 0, 0, 0, 0, 0, 1);
						return;
					end
					evictions++;
					if (dirty_of[v]) begin
						wb = 1;
						writes++;
					end
				end
				best = page_of[v];
				reads++;
				load_clk++;
				page_of[v] = pg;
				dirty_of[v] = 0;
				pins_of[v] = 1;
				used_at[v] = use_clk;
				loaded_at[v] = load_clk;
				push(ST_OK, v, 0, 1, wb, best, v, 1, 1);
			end else if (op == OP_FLUSH) begin
				cnt = 0;
				for (int i = 0; i < n; i++)
					if (dirty_of[i] && pins_of[i] == 0) begin
						dirty_of[i] = 0;
						writes++;
						push(ST_OK, i, 0, 0, 1, page_of[i], i, 0, 0);
						cnt++;
					end
				if (cnt == 0) push(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1);
				else pending[pending.size()-1].last = 1;
			end else if (op > OP_FLUSH || f < 0) begin
				push(ST_ABSENT, 0, 0, 0, 0, 0, 0, 0, 1);
			end else if (op == OP_UNPIN) begin
				if (pins_of[f] == 0) push(ST_ABSENT, f, 0, 0, 0, 0, 0, 0, 1);
				else begin
					pins_of[f]--;
					push(ST_OK, f, 0, 0, 0, 0, 0, pins_of[f], 1);
				end
			end else if (op == OP_DIRTY) begin
				dirty_of[f] = 1;
				push(ST_OK, f, 0, 0, 0, 0, 0, pins_of[f], 1);
			end else if (!dirty_of[f]) begin
				push(ST_ABSENT, f, 0, 0, 0, 0, 0, pins_of[f], 1);
			end else begin
				dirty_of[f] = 0;
				writes++;
				push(ST_OK, f, 0, 0, 1, page_of[f], f, pins_of[f], 1);
			end
		endfunction

		function void check_word(result_word_t got);
			result_word_t want;
			words_checked++;
			if (got.writeback) wb_seen++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch: st %0d/%0d fr %0d/%0d hit %0d/%0d rd %0d/%0d",
						want.status, got.status, want.frame_index, got.frame_index,
						want.hit, got.hit, want.read_request, got.read_request);
					$display("  wb %0d/%0d wpg %0d/%0d wfr %0d/%0d pins %0d/%0d",
						want.writeback, got.writeback, want.writeback_page,
						got.writeback_page, want.writeback_frame, got.writeback_frame,
						want.pin_count_now, got.pin_count_now);
					$display("  rio %0d/%0d wio %0d/%0d last %0d/%0d",
						want.read_io_count, got.read_io_count, want.write_io_count,
						got.write_io_count, want.last, got.last);
				end
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  opcode = 0;
	logic [30:0] page_number = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  status;
	logic [3:0]  frame_index;
	logic        hit, read_request, writeback, last;
	logic [30:0] writeback_page;
	logic [3:0]  writeback_frame;
	logic [15:0] pin_count_now;
	logic [31:0] read_io_count, write_io_count;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = 0;
	logic [4:0]  cfg_data = 0;

	pool_scoreboard pool = new();
	int  cycle_count = 0;
	bit  hold_off = 0;
	int  hold_cycles = 0;
	logic [30:0] recent_pages[8];

	page_frame_pool_replacer i_dut (.*);

	always #4 clk = ~clk;

	// cycle counter and timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// mostly short gaps, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// receiver with random stalls and a long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) pool.check_word({status, frame_index, hit,
				read_request, writeback, writeback_page, writeback_frame,
				pin_count_now, read_io_count, write_io_count, last});
			if (hold_off && hold_cycles < 400) begin
				hold_cycles <= hold_cycles + 1;
				out_ready <= 0;
			end else begin
				if (hold_off) hold_off <= 0;
				out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 99) < 5);
			end
		end
	end

	// valid drops only when a gap follows, so each edge sees one update
	task automatic send_word(logic [2:0] op, logic [30:0] pn);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		opcode <= op;
		page_number <= pn;
		do @(posedge clk); while (!in_ready);
		pool.note_input(op, pn);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pool.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [4:0] data);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		pool.write_reg(idx, data);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// mostly well-formed traffic over a small page set, with some bad opcodes, so hits and evictions happen
	task automatic random_phase(int count);
		int r;
		logic [30:0] pn;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 4) pn = 31'($urandom);
			else pn = recent_pages[$urandom_range(0, 7)];
			r = $urandom_range(0, 99);
			if (r < 40) send_word(OP_PIN, pn);
			else if (r < 65) send_word(OP_UNPIN, pn);
			else if (r < 80) send_word(OP_DIRTY, pn);
			else if (r < 88) send_word(OP_FORCE, pn);
			else if (r < 95) send_word(OP_FLUSH, 31'($urandom));
			else send_word(3'($urandom_range(5, 7)), 31'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) recent_pages[i] = 31'($urandom_range(0, 40));
		recent_pages[0] = '1;
		recent_pages[1] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every op, error cases
		send_word(OP_PIN, 31'h7FFF_FFFF);
		send_word(OP_PIN, 31'd0);
		send_word(OP_PIN, 31'd0);
		send_word(OP_DIRTY, 31'h7FFF_FFFF);
		send_word(OP_FORCE, 31'h7FFF_FFFF);
		send_word(OP_FORCE, 31'h7FFF_FFFF);
		send_word(OP_DIRTY, 31'd0);
		send_word(OP_UNPIN, 31'd0);
		send_word(OP_UNPIN, 31'd0);
		send_word(OP_UNPIN, 31'd0);
		send_word(OP_FLUSH, 31'd0);
		send_word(OP_FLUSH, 31'h2AAA_AAAA);
		send_word(OP_UNPIN, 31'h1234_5678);
		send_word(OP_DIRTY, 31'h5555_5555);
		send_word(OP_FORCE, 31'h0000_0001);
		send_word(3'd5, 31'd7);
		send_word(3'd7, 31'h7FFF_FFFF);

		// one frame, all pinned, then no-eviction strategies and pool sizes 0 and 31
		write_reg(REG_FRAMES, 5'd1);
		send_word(OP_PIN, 31'd99);
		write_reg(REG_STRATEGY, 5'd3);
		send_word(OP_UNPIN, 31'h7FFF_FFFF);
		send_word(OP_PIN, 31'd98);
		write_reg(REG_STRATEGY, 5'd2);
		send_word(OP_PIN, 31'd97);
		write_reg(REG_FRAMES, 5'd0);
		send_word(OP_PIN, 31'd5);
		send_word(OP_FLUSH, 31'd0);
		write_reg(REG_FRAMES, 5'd31);
		send_word(OP_PIN, 31'd5);

		// fifo, small pool, with long receiver hold-off while inputs keep coming
		write_reg(REG_STRATEGY, 5'd0);
		write_reg(REG_FRAMES, 5'd3);
		hold_off <= 1;
		random_phase(60);
		// lru, small pool
		write_reg(REG_STRATEGY, 5'd1);
		write_reg(REG_FRAMES, 5'd4);
		random_phase(90);
		write_reg(REG_FRAMES, 5'd16);
		random_phase(60);
		write_reg(REG_STRATEGY, 5'd0);
		write_reg(REG_FRAMES, 5'd2);
		random_phase(60);
		write_reg(REG_STRATEGY, 5'd1);
		write_reg(REG_FRAMES, 5'd5);
		random_phase(40);

		drain();
		$display("checked %0d result words: %0d hits, %0d evictions, %0d write-backs",
			pool.words_checked, pool.hits, pool.evictions, pool.wb_seen);
		$display("strategies fifo, lru and none; pool sizes 0 to 31");
		if (pool.errors == 0 && pool.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", pool.errors);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/pfp_pkg.sv
rtl/pfp_scan.sv
rtl/page_frame_pool_replacer.sv
sim/testbench.sv
